// ===== src/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

// ===== src/skt_cell.sv =====
`timescale 1ns / 1ps

module skt_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  skt_pkg::t_cell_ctrl     i_ctrl,
    input  logic [skt_pkg::KEY_W-1:0] i_key_cmp,
    input  logic [skt_pkg::KEY_W-1:0] i_key_new,
    input  logic [CW-1:0]           i_count,
    input  logic [skt_pkg::KEY_W-1:0] i_left_key,
    input  logic                    i_left_le,
    input  logic [skt_pkg::KEY_W-1:0] i_right_key,
    output logic [skt_pkg::KEY_W-1:0] o_key,
    output logic                    o_lt,
    output logic                    o_le
);

    localparam logic [CW-1:0] MyIdx = CW'(IDX);

    logic [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::KEY_W-1:0] n_key;
    logic                      r_lt;
    logic                      r_le;
    logic                      w_occupied;

    assign w_occupied = MyIdx < i_count;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins && !r_le) begin
            n_key = i_left_le ? i_key_new : i_left_key;
        end else if (i_ctrl.rem && !r_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctrl.capture) begin
            r_lt <= w_occupied && (r_key < i_key_cmp);
            r_le <= w_occupied && (r_key <= i_key_cmp);
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_le  = r_le;

endmodule

// ===== src/skt_therm_count.sv =====
`timescale 1ns / 1ps

module skt_therm_count #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  logic [DEPTH-1:0] i_therm,
    output logic [CW-1:0]    o_count
);

    logic [DEPTH:0] w_pad;

    assign w_pad = {1'b0, i_therm};

    // boundary of the run of ones gives the count
    always_comb begin
        o_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_pad[i] && !w_pad[i+1]) begin
                o_count = o_count | CW'(i + 1);
            end
        end
    end

endmodule

// ===== src/sorted_key_table_core.sv =====
`timescale 1ns / 1ps

// Sorted key table held in a row of TABLE_DEPTH cells, one key per cell.
// For each request (find, insert or remove), at the accepting edge every
// cell compares its key with the request key in parallel and stores the
// flags; in the execute state, once the output register is free, the
// flags are turned into a position, the cells shift one place towards or
// away from it, and the result is loaded into the output register. The
// next request is taken in the cycle after that, even while the previous
// result still waits; none is taken while a request is executing. Insert
// places the key after any equal keys; find and remove use the first
// equal key. The table is empty after reset with no clearing pass.

module sorted_key_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, key, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status, position, entry_count, zero fill
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

    skt_pkg::t_state              r_state;
    skt_pkg::t_state              n_state;
    logic [skt_pkg::OPCODE_W-1:0] r_op;
    logic [skt_pkg::KEY_W-1:0]    r_key;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [skt_pkg::STATUS_W-1:0] r_status;
    logic [skt_pkg::STATUS_W-1:0] n_status;
    logic [CW-1:0]                r_pos;
    logic [CW-1:0]                n_pos;
    logic                         w_load;

    skt_pkg::t_cell_ctrl          w_ctrl;
    logic                         w_accept;
    logic [TABLE_DEPTH-1:0]       w_lt;
    logic [TABLE_DEPTH-1:0]       w_le;
    logic [skt_pkg::KEY_W-1:0]    w_keys [TABLE_DEPTH];
    logic [CW-1:0]                w_pos_lt;
    logic [CW-1:0]                w_pos_le;
    logic                         w_found;
    logic                         w_full;
    logic [CW+skt_pkg::POSITION_W-1:0] w_pos_ext;
    logic [CW+skt_pkg::COUNT_W-1:0]    w_cnt_ext;

    assign s_axis_tready = (r_state == skt_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [skt_pkg::KEY_W-1:0] w_left_key;
            logic                      w_left_le;
            logic [skt_pkg::KEY_W-1:0] w_right_key;
            if (g == 0) begin : g_first
                assign w_left_key = r_key;
                assign w_left_le  = 1'b1;
            end else begin : g_mid
                assign w_left_key = w_keys[g-1];
                assign w_left_le  = w_le[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_right_key = w_keys[g];
            end else begin : g_inner
                assign w_right_key = w_keys[g+1];
            end
            skt_cell #(
                .CW  (CW),
                .IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_key_cmp   (s_axis_tdata[33:2]),
                .i_key_new   (r_key),
                .i_count     (r_count),
                .i_left_key  (w_left_key),
                .i_left_le   (w_left_le),
                .i_right_key (w_right_key),
                .o_key       (w_keys[g]),
                .o_lt        (w_lt[g]),
                .o_le        (w_le[g])
            );
        end
    endgenerate

    skt_therm_count #(
        .DEPTH (TABLE_DEPTH),
        .CW    (CW)
    ) u_count_lt (
        .i_therm (w_lt),
        .o_count (w_pos_lt)
    );

    skt_therm_count #(
        .DEPTH (TABLE_DEPTH),
        .CW    (CW)
    ) u_count_le (
        .i_therm (w_le),
        .o_count (w_pos_le)
    );

    assign w_found = w_pos_le != w_pos_lt;
    assign w_full  = r_count == FullCount;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_status       = r_status;
        n_pos          = r_pos;
        n_out_valid    = r_out_valid && !m_axis_tready;
        w_load         = 1'b0;
        w_ctrl.capture = w_accept;
        w_ctrl.ins     = 1'b0;
        w_ctrl.rem     = 1'b0;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = skt_pkg::S_EXEC;
                end
            end
            skt_pkg::S_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = skt_pkg::S_IDLE;
                    unique case (r_op)
                        skt_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_status = skt_pkg::ST_FULL;
                                n_pos    = '0;
                            end else begin
                                w_ctrl.ins = 1'b1;
                                n_status   = skt_pkg::ST_OK;
                                n_pos      = w_pos_le;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        skt_pkg::OP_REMOVE: begin
                            if (w_found) begin
                                w_ctrl.rem = 1'b1;
                                n_status   = skt_pkg::ST_OK;
                                n_pos      = w_pos_lt;
                                n_count    = r_count - 1'b1;
                            end else begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                                n_pos    = '0;
                            end
                        end
                        default: begin
                            if (w_found) begin
                                n_status = skt_pkg::ST_OK;
                                n_pos    = w_pos_lt;
                            end else begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                                n_pos    = '0;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tdata[1:0];
            r_key <= s_axis_tdata[33:2];
        end
        if (w_load) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    assign w_pos_ext = {{skt_pkg::POSITION_W{1'b0}}, r_pos};
    assign w_cnt_ext = {{skt_pkg::COUNT_W{1'b0}}, r_count};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, w_cnt_ext[skt_pkg::COUNT_W-1:0],
                            w_pos_ext[skt_pkg::POSITION_W-1:0], r_status};

endmodule
